/* hdl/gnf_pkg.sv */
// Package for the gradient noise fractal block: types, codes and constants.
`timescale 1ns / 1ps

package gnf_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_TABLE_SIZE  = 256;
    localparam int DEF_MAX_OCTAVES = 16;

    // Command codes carried in func.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [1:0] REG_PERSISTENCE  = 2'd1;
    localparam logic [1:0] REG_BASE_SCALE   = 2'd2;

    // Configuration reset values.
    localparam logic [4:0]  RST_OCTAVE_COUNT = 5'd1;
    localparam logic [15:0] RST_PERSISTENCE  = 16'd16384;
    localparam logic [23:0] RST_BASE_SCALE   = 24'd65536;

    // Hash constants.
    localparam logic signed [32:0] HASH_MUL_X   = 33'sd1619;
    localparam logic signed [32:0] HASH_MUL_Y   = 33'sd31337;
    localparam logic signed [32:0] HASH_MUL_XY  = 33'sd19997;
    localparam logic signed [32:0] HASH_MUL_CUB = 33'sd15731;
    localparam logic [31:0]        HASH_ADD     = 32'd789221;

    // Fade polynomial constants in Q.16.
    localparam logic signed [21:0] FADE_SUB = 22'sd983040;
    localparam logic signed [21:0] FADE_ADD = 22'sd655360;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_FADE_A,
        ST_FADE_B,
        ST_FADE_C,
        ST_FADE_D,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_H5,
        ST_H6,
        ST_H7,
        ST_H8,
        ST_H9,
        ST_READ,
        ST_DOT_X,
        ST_DOT_Y,
        ST_BLEND_0,
        ST_BLEND_1,
        ST_BLEND_V,
        ST_ACC_SUM,
        ST_ACC_AMP,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_FINISH
    } state_t;

endpackage

/* hdl/gradient_noise_fractal_top.sv */
// Top level of the gradient noise fractal block: sequencer, gradient memory and datapath.
// A write transaction returns nothing; an evaluate transaction returns its done strobe once
// the sequencer has run all N octaves and the division (straight after scaling if N is zero).
// Throughput: one transaction at a time; the rate is set by the single shared multiplier,
// used by every octave, and the one-bit-per-cycle divider of the final normalization.
// Reset clears the sequencer and loads the register defaults; gradient entries hold no reset.
`timescale 1ns / 1ps

module gradient_noise_fractal_top
    import gnf_pkg::*;
#(
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [7:0]         entry_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] noise_value
);

    localparam int ADDR_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    localparam int TOT_W  = 53 + OCT_W;
    localparam int SUM_W  = 32 + OCT_W;
    localparam int REM_W  = SUM_W + 1;
    localparam int DCNT_W = $clog2(TOT_W);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TABLE_SIZE);
    localparam logic [32:0] TSIZE = 33'(TABLE_SIZE);

    // Configuration registers.
    logic [4:0]  octave_count_reg;
    logic [15:0] persistence_reg;
    logic [23:0] base_scale_reg;

    // Sequencer state.
    state_t state_reg, state_next;
    logic   axis_reg;
    logic [1:0] corner_reg;
    logic [OCT_W-1:0] oct_reg, n_reg, oct_inc;
    logic [DCNT_W-1:0] div_cnt_reg;

    // Datapath registers.
    logic signed [31:0] cx_in_reg, cy_in_reg;
    logic [47:0]        px_reg, py_reg;
    logic signed [21:0] b_reg, fx_reg, fy_reg;
    logic [15:0]        t_reg;
    logic [31:0]        h_reg, g_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic [31:0]        rdata_reg;
    logic signed [33:0] dot_reg;
    logic signed [35:0] d0_reg, d1_reg, d2_reg, d3_reg, v_reg;
    logic [31:0]        amp_reg;
    logic [SUM_W-1:0]   amp_sum_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0]   quo_reg;
    logic [REM_W-1:0]   rem_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [15:0] noise_reg;

    // Gradient memory.
    logic [31:0] grad_mem [TABLE_SIZE];

    // Shared multiplier and its operands.
    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [68:0] prod;
    logic               rd_en;

    // Derived per-octave values.
    logic [31:0] sx, sy, x0, y0, x1, y1, cx, cy;
    logic [15:0] ux, uy, u;
    logic signed [21:0] fade_a;
    logic signed [16:0] dx, dy;
    logic accept, wr_ok;
    logic [ADDR_W-1:0] waddr;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign noise_value = noise_reg;
    assign wr_ok   = (32'(entry_index) < 32'(TABLE_SIZE));
    assign waddr   = ADDR_W'(entry_index);
    assign oct_inc = oct_reg + 1'b1;

    assign sx = px_reg[47:16];
    assign sy = py_reg[47:16];
    assign x0 = {{16{sx[31]}}, sx[31:16]};
    assign y0 = {{16{sy[31]}}, sy[31:16]};
    assign x1 = x0 + 32'd1;
    assign y1 = y0 + 32'd1;
    assign ux = sx[15:0];
    assign uy = sy[15:0];
    assign u  = axis_reg ? uy : ux;
    assign cx = corner_reg[0] ? x1 : x0;
    assign cy = corner_reg[1] ? y1 : y0;
    assign dx = $signed({corner_reg[0], ux});
    assign dy = $signed({corner_reg[1], uy});
    assign fade_a = $signed({4'b0, u, 2'b0}) + $signed({5'b0, u, 1'b0}) - FADE_SUB;

    assign prod = mul_a * mul_b;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= RST_OCTAVE_COUNT;
            persistence_reg  <= RST_PERSISTENCE;
            base_scale_reg   <= RST_BASE_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[4:0];
                REG_PERSISTENCE:  persistence_reg  <= cfg_data[15:0];
                REG_BASE_SCALE:   base_scale_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Gradient memory: write on a write transaction, registered read for the sequencer.
    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_WRITE && wr_ok)
        begin
            grad_mem[waddr] <= {grad_y, grad_x};
        end
        if (rd_en)
        begin
            rdata_reg <= grad_mem[slot_reg];
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start && func == FUNC_EVAL)
                    state_next = ST_SCALE_X;
            ST_SCALE_X:  state_next = ST_SCALE_Y;
            ST_SCALE_Y:  state_next = (n_reg == '0) ? ST_FINISH : ST_FADE_A;
            ST_FADE_A:   state_next = ST_FADE_B;
            ST_FADE_B:   state_next = ST_FADE_C;
            ST_FADE_C:   state_next = ST_FADE_D;
            ST_FADE_D:   state_next = axis_reg ? ST_H1 : ST_FADE_A;
            ST_H1:       state_next = ST_H2;
            ST_H2:       state_next = ST_H3;
            ST_H3:       state_next = ST_H4;
            ST_H4:       state_next = ST_H5;
            ST_H5:       state_next = ST_H6;
            ST_H6:       state_next = ST_H7;
            ST_H7:       state_next = ST_H8;
            ST_H8:       state_next = ST_H9;
            ST_H9:       state_next = ST_READ;
            ST_READ:     state_next = ST_DOT_X;
            ST_DOT_X:    state_next = ST_DOT_Y;
            ST_DOT_Y:    state_next = (corner_reg == 2'd3) ? ST_BLEND_0 : ST_H1;
            ST_BLEND_0:  state_next = ST_BLEND_1;
            ST_BLEND_1:  state_next = ST_BLEND_V;
            ST_BLEND_V:  state_next = ST_ACC_SUM;
            ST_ACC_SUM:  state_next = ST_ACC_AMP;
            ST_ACC_AMP:  state_next = (oct_inc == n_reg) ? ST_DIV_INIT : ST_FADE_A;
            ST_DIV_INIT: state_next = ST_DIV_STEP;
            ST_DIV_STEP:
                if (div_cnt_reg == DCNT_W'(TOT_W - 1))
                    state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Output logic: multiplier operands and the memory read enable for each state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        rd_en = 1'b0;
        unique case (state_reg)
            ST_SCALE_X:
            begin
                mul_a = 36'(cx_in_reg);
                mul_b = $signed({9'b0, base_scale_reg});
            end
            ST_SCALE_Y:
            begin
                mul_a = 36'(cy_in_reg);
                mul_b = $signed({9'b0, base_scale_reg});
            end
            ST_FADE_A:
            begin
                mul_a = 36'(fade_a);
                mul_b = $signed({17'b0, u});
            end
            ST_FADE_B:
            begin
                mul_a = $signed({20'b0, u});
                mul_b = $signed({17'b0, u});
            end
            ST_FADE_C:
            begin
                mul_a = $signed({20'b0, t_reg});
                mul_b = $signed({17'b0, u});
            end
            ST_FADE_D:
            begin
                mul_a = 36'(b_reg);
                mul_b = $signed({17'b0, t_reg});
            end
            ST_H1:
            begin
                mul_a = $signed({4'b0, cx});
                mul_b = HASH_MUL_X;
            end
            ST_H2:
            begin
                mul_a = $signed({4'b0, cy});
                mul_b = HASH_MUL_Y;
            end
            ST_H3:
            begin
                mul_a = $signed({4'b0, cx});
                mul_b = $signed({1'b0, cy});
            end
            ST_H4:
            begin
                mul_a = $signed({4'b0, g_reg});
                mul_b = HASH_MUL_XY;
            end
            ST_H5:
            begin
                mul_a = $signed({4'b0, h_reg});
                mul_b = $signed({1'b0, h_reg});
            end
            ST_H6:
            begin
                mul_a = $signed({4'b0, g_reg});
                mul_b = $signed({1'b0, h_reg});
            end
            ST_H7:
            begin
                mul_a = $signed({4'b0, g_reg});
                mul_b = HASH_MUL_CUB;
            end
            ST_H8:
            begin
                mul_a = $signed({4'b0, h_reg});
                mul_b = $signed(RECIP);
            end
            ST_H9:
            begin
                mul_a = $signed({4'b0, g_reg});
                mul_b = $signed(TSIZE);
            end
            ST_READ:     rd_en = 1'b1;
            ST_DOT_X:
            begin
                mul_a = 36'(dx);
                mul_b = 33'($signed(rdata_reg[15:0]));
            end
            ST_DOT_Y:
            begin
                mul_a = 36'(dy);
                mul_b = 33'($signed(rdata_reg[31:16]));
            end
            ST_BLEND_0:
            begin
                mul_a = d1_reg - d0_reg;
                mul_b = 33'(fx_reg);
            end
            ST_BLEND_1:
            begin
                mul_a = d3_reg - d2_reg;
                mul_b = 33'(fx_reg);
            end
            ST_BLEND_V:
            begin
                mul_a = d2_reg - d0_reg;
                mul_b = 33'(fy_reg);
            end
            ST_ACC_SUM:
            begin
                mul_a = 36'($signed(v_reg[35:16]));
                mul_b = $signed({1'b0, amp_reg});
            end
            ST_ACC_AMP:
            begin
                mul_a = $signed({4'b0, amp_reg});
                mul_b = $signed({17'b0, persistence_reg});
            end
            default:     ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 1'b0;
            corner_reg  <= 2'd0;
            oct_reg     <= '0;
            n_reg       <= '0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
            if (accept)
            begin
                oct_reg <= '0;
                n_reg   <= (32'(octave_count_reg) > 32'(MAX_OCTAVES)) ?
                           OCT_W'(MAX_OCTAVES) : OCT_W'(octave_count_reg);
            end
            if (state_reg == ST_FADE_D)
            begin
                axis_reg <= ~axis_reg;
            end
            if (state_reg == ST_DOT_Y)
            begin
                corner_reg <= corner_reg + 2'd1;
            end
            if (state_reg == ST_ACC_AMP)
            begin
                oct_reg <= oct_inc;
            end
            if (state_reg == ST_DIV_INIT)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV_STEP)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        logic [31:0]      hw;
        logic [31:0]      hf;
        logic [32:0]      rem33;
        logic [33:0]      amp_p;
        logic [REM_W-1:0] rem_sh;
        logic [TOT_W-1:0] q_mag;

        hw    = prod[31:0] + HASH_ADD;
        hf    = hw ^ {{16{hw[31]}}, hw[31:16]};
        rem33 = {1'b0, h_reg} - prod[32:0];
        amp_p = prod[48:15];
        rem_sh = {rem_reg[REM_W-2:0], quo_reg[TOT_W-1]};
        q_mag = quo_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cx_in_reg   <= coord_x;
                cy_in_reg   <= coord_y;
                amp_reg     <= 32'd32768;
                amp_sum_reg <= '0;
                total_reg   <= '0;
            end
            ST_SCALE_X:  px_reg <= prod[47:0];
            ST_SCALE_Y:
            begin
                py_reg  <= prod[47:0];
                quo_reg <= '0;
                neg_reg <= 1'b0;
            end
            ST_FADE_A:   b_reg <= prod[37:16] + FADE_ADD;
            ST_FADE_B:   t_reg <= prod[31:16];
            ST_FADE_C:   t_reg <= prod[31:16];
            ST_FADE_D:
                if (axis_reg)
                    fy_reg <= prod[37:16];
                else
                    fx_reg <= prod[37:16];
            ST_H1:       h_reg <= prod[31:0];
            ST_H2:       h_reg <= h_reg + prod[31:0];
            ST_H3:       g_reg <= prod[31:0];
            ST_H4:       h_reg <= h_reg ^ prod[31:0];
            ST_H5:       g_reg <= prod[31:0];
            ST_H6:       g_reg <= prod[31:0];
            ST_H7:       h_reg <= hf[31] ? (32'd0 - hf) : hf;
            ST_H8:       g_reg <= prod[63:32];
            ST_H9:
                // The reciprocal estimate is at most one short of the quotient.
                if (rem33 >= TSIZE)
                    slot_reg <= ADDR_W'(rem33 - TSIZE);
                else
                    slot_reg <= ADDR_W'(rem33);
            ST_DOT_X:    dot_reg <= prod[33:0];
            ST_DOT_Y:
            begin
                unique case (corner_reg)
                    2'd0:    d0_reg <= 36'(dot_reg) + 36'($signed(prod[33:0]));
                    2'd1:    d1_reg <= 36'(dot_reg) + 36'($signed(prod[33:0]));
                    2'd2:    d2_reg <= 36'(dot_reg) + 36'($signed(prod[33:0]));
                    default: d3_reg <= 36'(dot_reg) + 36'($signed(prod[33:0]));
                endcase
            end
            ST_BLEND_0:  d0_reg <= d0_reg + prod[51:16];
            ST_BLEND_1:  d2_reg <= d2_reg + prod[51:16];
            ST_BLEND_V:  v_reg  <= d0_reg + prod[51:16];
            ST_ACC_SUM:
            begin
                total_reg   <= total_reg + TOT_W'($signed(prod[52:0]));
                amp_sum_reg <= amp_sum_reg + SUM_W'(amp_reg);
            end
            ST_ACC_AMP:
            begin
                amp_reg <= (amp_p[33:32] != 2'b00) ? 32'hFFFF_FFFF : amp_p[31:0];
                px_reg  <= {px_reg[46:0], 1'b0};
                py_reg  <= {py_reg[46:0], 1'b0};
            end
            ST_DIV_INIT:
            begin
                neg_reg <= total_reg[TOT_W-1];
                quo_reg <= total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
                rem_reg <= '0;
            end
            ST_DIV_STEP:
            begin
                // Restoring division, one quotient bit per cycle.
                if (rem_sh >= REM_W'(amp_sum_reg))
                begin
                    rem_reg <= rem_sh - REM_W'(amp_sum_reg);
                    quo_reg <= {quo_reg[TOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[TOT_W-2:0], 1'b0};
                end
            end
            ST_FINISH:
            begin
                // Apply the sign and saturate to the output range.
                if (neg_reg)
                    noise_reg <= (q_mag > TOT_W'(32768)) ? 16'sh8000 : 16'(-q_mag);
                else
                    noise_reg <= (q_mag > TOT_W'(32767)) ? 16'sh7FFF : 16'(q_mag);
            end
            default:     ;
        endcase
    end

endmodule

/* sim/tb_gradient_noise_fractal_top.sv */
// Self-checking testbench for the gradient noise fractal block: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_gradient_noise_fractal_top
    import gnf_pkg::*;
();

    // One row of directed stimulus; known marks rows whose result is typed in known_val.
    typedef struct packed {
        logic [4:0]         octaves;
        logic               op;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [7:0]         slot;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic               known;
        logic signed [15:0] known_val;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [7:0]         entry_index;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               done;
    logic signed [15:0] noise_value;

    // Predictor state: shadow registers and gradient memory.
    logic [31:0]        grad_mem [0:255];
    int unsigned        octaves_q;
    int unsigned        persist_q;
    int unsigned        scale_q;

    // Expected noise values, oldest first.
    logic signed [15:0] noise_expected [$];
    int                 mismatches;
    dir_row_t           dir_rows [$];

    gradient_noise_fractal_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .entry_index (entry_index),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .noise_value (noise_value)
    );

    // Clock generation, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Lattice hash that picks the gradient slot of one corner.
    function automatic int unsigned corner_hash(int unsigned x, int unsigned y);
        int unsigned h;
        int unsigned sh;
        h = x * 32'd1619 + y * 32'd31337;
        h = h ^ ((x * y) * 32'd19997);
        h = h * h * h * 32'd15731 + 32'd789221;
        sh = h >> 16;
        if (h[31])
        begin
            sh = sh | 32'hFFFF0000;
        end
        h = h ^ sh;
        if (h[31])
        begin
            h = 32'd0 - h;
        end
        return h % 32'd256;
    endfunction

    function automatic longint corner_grad_dot(longint dx, longint dy, int unsigned x,
                                               int unsigned y);
        logic [31:0] e;
        e = grad_mem[corner_hash(x, y)];
        return dx * longint'($signed(e[15:0])) + dy * longint'($signed(e[31:16]));
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16.
    function automatic longint quintic_fade(longint u);
        longint a;
        longint b;
        longint c;
        a = 6 * u - 983040;
        b = ((u * a) >>> 16) + 655360;
        c = (((u * u) >>> 16) * u) >>> 16;
        return (c * b) >>> 16;
    endfunction

    function automatic longint mix(longint p, longint q, longint f);
        return p + ((f * (q - p)) >>> 16);
    endfunction

    // Fractal noise at one point under the current shadow registers.
    function automatic logic signed [15:0] fractal_noise(logic signed [31:0] cx,
                                                         logic signed [31:0] cy);
        int unsigned n;
        longint      px;
        longint      py;
        logic [63:0] wide;
        logic [31:0] sx;
        logic [31:0] sy;
        int unsigned x0;
        int unsigned y0;
        longint      ux;
        longint      uy;
        longint      fx;
        longint      fy;
        longint      oct_val;
        longint      amp;
        longint      amp_sum;
        longint      total;
        longint      q;
        n = (octaves_q > 16) ? 16 : octaves_q;
        px = longint'(cx) * longint'(scale_q);
        py = longint'(cy) * longint'(scale_q);
        amp = 32768;
        amp_sum = 0;
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            wide = px << i;
            sx = wide[47:16];
            wide = py << i;
            sy = wide[47:16];
            x0 = {{16{sx[31]}}, sx[31:16]};
            y0 = {{16{sy[31]}}, sy[31:16]};
            ux = longint'(sx[15:0]);
            uy = longint'(sy[15:0]);
            fx = quintic_fade(ux);
            fy = quintic_fade(uy);
            oct_val = mix(mix(corner_grad_dot(ux, uy, x0, y0),
                              corner_grad_dot(ux - 65536, uy, x0 + 1, y0), fx),
                          mix(corner_grad_dot(ux, uy - 65536, x0, y0 + 1),
                              corner_grad_dot(ux - 65536, uy - 65536, x0 + 1, y0 + 1), fx),
                          fy);
            total += (oct_val >>> 16) * amp;
            amp_sum += amp;
            amp = (amp * longint'(persist_q)) >>> 15;
            if (amp > 64'hFFFFFFFF)
            begin
                amp = 64'hFFFFFFFF;
            end
        end
        q = (amp_sum == 0) ? 0 : total / amp_sum;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    // Result checker: each strobe is compared with the oldest expected value.
    always @(posedge clk)
    begin
        if (done)
        begin
            if (noise_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected result noise_value=%0d", noise_value);
                end
            end
            else
            begin
                if (noise_value !== noise_expected[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: noise_value expected %0d got %0d",
                                 noise_expected[0], noise_value);
                    end
                end
                void'(noise_expected.pop_front());
            end
        end
    end

    // Run time limit.
    initial
    begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Issue one transaction; entered and left at a falling edge.
    task automatic send_item(logic op, logic signed [31:0] cx, logic signed [31:0] cy,
                             logic [7:0] slot, logic signed [15:0] gx,
                             logic signed [15:0] gy, logic known, logic signed [15:0] val);
        while (busy)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        func <= op;
        coord_x <= cx;
        coord_y <= cy;
        entry_index <= slot;
        grad_x <= gx;
        grad_y <= gy;
        if (op == FUNC_WRITE)
        begin
            grad_mem[slot] = {gy, gx};
        end
        else
        begin
            noise_expected.push_back(known ? val : fractal_noise(cx, cy));
        end
        @(negedge clk);
    endtask

    // Wait until every expected result has arrived and the block is quiet.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (noise_expected.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Register write while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_OCTAVE_COUNT: octaves_q = data[4:0];
            REG_PERSISTENCE:  persist_q = data[15:0];
            REG_BASE_SCALE:   scale_q = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_row(logic [4:0] oc, logic op, logic signed [31:0] cx,
                           logic signed [31:0] cy, logic [7:0] slot, logic signed [15:0] gx,
                           logic signed [15:0] gy, logic known, logic signed [15:0] val);
        dir_rows.push_back('{oc, op, cx, cy, slot, gx, gy, known, val});
    endtask

    // Random gradient component, mostly inside Q1.14 unit range.
    function automatic logic signed [15:0] rand_grad();
        if ($urandom_range(0, 9) == 0)
        begin
            return 16'($urandom());
        end
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            2: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
            default: return $urandom_range(0, 32'h7FFF) << $urandom_range(0, 16);
        endcase
    endfunction

    // Main stimulus.
    initial
    begin
        int          burst;
        int          phase_items;
        int          item_count;
        logic [23:0] scale_pick;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_WRITE;
        coord_x = '0;
        coord_y = '0;
        entry_index = '0;
        grad_x = '0;
        grad_y = '0;
        cfg_we = 1'b0;
        cfg_index = REG_OCTAVE_COUNT;
        cfg_data = '0;
        mismatches = 0;
        octaves_q = RST_OCTAVE_COUNT;
        persist_q = RST_PERSISTENCE;
        scale_q = RST_BASE_SCALE;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole gradient memory so no evaluation reads an unwritten entry.
        for (int i = 0; i < 256; i++)
        begin
            send_item(FUNC_WRITE, $urandom(), $urandom(), i[7:0], rand_grad(), rand_grad(),
                      1'b0, '0);
        end

        // Directed rows: extremes of fields and registers, zero octaves, clamping.
        add_row(5'd1, FUNC_EVAL, 32'sd0, 32'sd0, 8'd0, 16'sd0, 16'sd0, 1'b1, 16'sd0);
        add_row(5'd1, FUNC_EVAL, 32'sh00030000, -32'sh00050000, 8'd0, 16'sd0, 16'sd0,
                1'b1, 16'sd0);
        add_row(5'd1, FUNC_EVAL, 32'sh00008000, 32'sh00004000, 8'd0, 16'sd0, 16'sd0,
                1'b0, '0);
        add_row(5'd1, FUNC_WRITE, 32'sd0, 32'sd0, 8'd0, -16'sd16384, 16'sd16384, 1'b0, '0);
        add_row(5'd1, FUNC_WRITE, -32'sd1, -32'sd1, 8'd255, 16'sd16384, -16'sd16384,
                1'b0, '0);
        add_row(5'd1, FUNC_WRITE, 32'sd0, 32'sd0, 8'd128, 16'sh7FFF, 16'sh8000, 1'b0, '0);
        add_row(5'd1, FUNC_EVAL, 32'sh7FFFFFFF, 32'sh80000000, 8'hFF, 16'sd0, 16'sd0,
                1'b0, '0);
        add_row(5'd1, FUNC_EVAL, 32'sh80000000, 32'sh7FFFFFFF, 8'd0, 16'sd0, 16'sd0,
                1'b0, '0);
        add_row(5'd1, FUNC_EVAL, -32'sd1, -32'sd1, 8'd0, 16'sd0, 16'sd0, 1'b0, '0);
        add_row(5'd0, FUNC_EVAL, 32'sh12345678, -32'sh0ABCDEF0, 8'd0, 16'sd0, 16'sd0,
                1'b1, 16'sd0);
        add_row(5'd0, FUNC_EVAL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 8'd0, 16'sd0, 16'sd0,
                1'b1, 16'sd0);
        add_row(5'd0, FUNC_WRITE, 32'sd0, 32'sd0, 8'd7, 16'sd100, -16'sd100, 1'b0, '0);
        add_row(5'd16, FUNC_EVAL, 32'sh00018000, 32'sh0002C000, 8'd0, 16'sd0, 16'sd0,
                1'b0, '0);
        add_row(5'd16, FUNC_EVAL, 32'sh80000000, 32'sh80000000, 8'd0, 16'sd0, 16'sd0,
                1'b0, '0);
        add_row(5'd31, FUNC_EVAL, 32'sh00018000, 32'sh0002C000, 8'd0, 16'sd0, 16'sd0,
                1'b0, '0);
        add_row(5'd31, FUNC_EVAL, -32'sh00007777, 32'sh00123456, 8'd0, 16'sd0, 16'sd0,
                1'b0, '0);
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].octaves != octaves_q)
            begin
                write_reg(REG_OCTAVE_COUNT, {19'd0, dir_rows[r].octaves});
            end
            send_item(dir_rows[r].op, dir_rows[r].cx, dir_rows[r].cy, dir_rows[r].slot,
                      dir_rows[r].gx, dir_rows[r].gy, dir_rows[r].known,
                      dir_rows[r].known_val);
        end

        // Persistence and scale extremes with a few octaves.
        write_reg(REG_PERSISTENCE, 24'hFFFFFF);
        write_reg(REG_BASE_SCALE, 24'hFFFFFF);
        write_reg(REG_OCTAVE_COUNT, 24'd4);
        send_item(FUNC_EVAL, 32'sh7FFFFFFF, -32'sd1, 8'd0, 16'sd0, 16'sd0, 1'b0, '0);
        write_reg(REG_PERSISTENCE, 24'd0);
        write_reg(REG_BASE_SCALE, 24'd0);
        send_item(FUNC_EVAL, 32'sh01234567, 32'sh76543210, 8'd0, 16'sd0, 16'sd0, 1'b0, '0);

        // Random phases, each under its own register setting.
        item_count = 0;
        for (int ph = 0; item_count < 1620; ph++)
        begin
            if (ph % 8 == 7)
            begin
                write_reg(REG_OCTAVE_COUNT, 24'($urandom_range(12, 31)));
                phase_items = 25;
            end
            else
            begin
                write_reg(REG_OCTAVE_COUNT,
                          (ph % 8 == 3) ? 24'd0 : 24'($urandom_range(1, 4)));
                phase_items = 150;
            end
            write_reg(REG_PERSISTENCE, (ph % 5 == 0) ? 24'(24'hFF0000 | $urandom_range(0, 3))
                                                     : 24'($urandom()));
            case ($urandom_range(0, 3))
                0: scale_pick = 24'($urandom());
                1: scale_pick = 24'(24'hFFFFFF - $urandom_range(0, 255));
                default: scale_pick = 24'($urandom_range(0, 24'h03FFFF));
            endcase
            write_reg(REG_BASE_SCALE, scale_pick);
            while (phase_items > 0)
            begin
                // A burst of back-to-back transactions, then most often a gap.
                burst = $urandom_range(1, 12);
                while (burst > 0 && phase_items > 0)
                begin
                    if ($urandom_range(0, 9) < 4)
                    begin
                        send_item(FUNC_WRITE, $urandom(), $urandom(), 8'($urandom()),
                                  rand_grad(), rand_grad(), 1'b0, '0);
                    end
                    else
                    begin
                        send_item(FUNC_EVAL, rand_coord(), rand_coord(), 8'($urandom()),
                                  16'($urandom()), 16'($urandom()), 1'b0, '0);
                    end
                    burst--;
                    phase_items--;
                    item_count++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(negedge clk);
                end
                if ($urandom_range(0, 30) == 0)
                begin
                    drain_results();
                end
            end
        end

        // Let the last results arrive, then report.
        drain_results();
        repeat (70) @(negedge clk);
        if (mismatches == 0 && noise_expected.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
